FILE: rtl/core/kss_pkg.sv
// Shared types and constants for the k-sorted stream sorter.
package kss_pkg;

  localparam int unsigned WindowDepthDefault = 16;
  localparam int unsigned ValueWidth         = 32;
  localparam int unsigned LimitWidth         = 4;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [LimitWidth-1:0]        limit_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the incoming value in order
    logic pop;     // shift the chain one cell toward the head
  } cell_ctrl_t;

endpackage

FILE: rtl/core/kss_in_if.sv
// Input item channel: one stream element and its end-of-stream flag.
interface kss_in_if;
  logic            valid;
  logic            ready;
  kss_pkg::value_t value;
  logic            stream_end;

  modport source (output valid, output value, output stream_end, input ready);
  modport sink   (input valid, input value, input stream_end, output ready);
endinterface

FILE: rtl/core/kss_out_if.sv
// Output item channel: one sorted element and its final-of-stream flag.
interface kss_out_if;
  logic            valid;
  logic            ready;
  kss_pkg::value_t sorted_value;
  logic            final_result;

  modport source (output valid, output sorted_value, output final_result, input ready);
  modport sink   (input valid, input sorted_value, input final_result, output ready);
endinterface

FILE: rtl/core/kss_cfg_if.sv
// Configuration write channel carrying the displacement limit.
interface kss_cfg_if;
  logic            valid;
  logic            ready;
  kss_pkg::limit_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/kss_cell.sv
// One cell of the ordered insertion chain: holds a single stored value.
module kss_cell (
  input  logic                clk_i,
  input  kss_pkg::cell_ctrl_t ctrl_i,
  input  kss_pkg::value_t     value_i,      // incoming item value (broadcast)
  input  logic                valid_i,      // this cell holds a live entry
  input  kss_pkg::value_t     left_val_i,   // stored value of the cell toward the head
  input  logic                left_ins_i,   // insertion point lies at or before the left cell
  input  kss_pkg::value_t     right_mid_i,  // post-insert value of the cell toward the tail
  output kss_pkg::value_t     val_o,
  output logic                ins_o,
  output kss_pkg::value_t     mid_o
);

  kss_pkg::value_t val_q, val_d;

  // Insertion point: first empty cell or first cell strictly greater
  assign ins_o = !valid_i || (val_q > value_i);

  // Value after the insert step, before any pop
  always_comb begin
    mid_o = val_q;
    if (ctrl_i.insert && ins_o) begin
      mid_o = left_ins_i ? left_val_i : value_i;
    end
  end

  // Pop takes the neighbor's post-insert value
  assign val_d = ctrl_i.pop ? right_mid_i : mid_o;
  assign val_o = val_q;

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: rtl/core/k_sorted_stream_sorter.sv
// k_sorted_stream_sorter: sorts a k-sorted stream with a chain of insertion cells.
// A non-final item taken with lim_eff or more entries held pops the head to the output register.
// Throughput: a non-final item is taken every cycle while the output register can move.
// A final item is inserted and its flush then moves all n+1 entries out through the output
// register, one per cycle while it can move; no item is taken during the flush.
// Reset clears the held count, flush state, output valid and the limit; cell data is not reset.
module k_sorted_stream_sorter #(
  parameter int unsigned WINDOW_DEPTH = kss_pkg::WindowDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kss_cfg_if.sink    cfg_i,
  kss_in_if.sink     in_i,
  kss_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);

  kss_pkg::limit_t     limit_q;
  logic [CntW-1:0]     count_q, count_d;
  logic                drain_q, drain_d;
  logic                out_valid_q, out_valid_d;
  kss_pkg::value_t     out_value_q, out_value_d;
  logic                out_final_q, out_final_d;

  logic [CntW-1:0]     lim_eff;
  logic [CntW-1:0]     count_plus;
  logic                slot_free;
  logic                accept_in;
  kss_pkg::cell_ctrl_t ctrl;

  kss_pkg::value_t     cell_val [WINDOW_DEPTH];
  kss_pkg::value_t     cell_mid [WINDOW_DEPTH];
  logic                cell_ins [WINDOW_DEPTH];

  // Config register, always writable
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  // Effective window: min(k, depth - 1)
  assign lim_eff = (32'(limit_q) > 32'(WINDOW_DEPTH - 1)) ? CntW'(WINDOW_DEPTH - 1)
                                                          : CntW'(limit_q);

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !drain_q && slot_free;
  assign accept_in  = in_i.valid && in_i.ready;
  assign count_plus = count_q + CntW'(1);

  // Chain of cells
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic            valid_c;
    kss_pkg::value_t left_val;
    logic            left_ins;
    kss_pkg::value_t right_mid;

    assign valid_c = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_val = cell_val[0];
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_ins = cell_ins[i-1];
    end

    if (i == WINDOW_DEPTH - 1) begin : g_tail
      assign right_mid = cell_mid[i];
    end else begin : g_inner
      assign right_mid = cell_mid[i+1];
    end

    kss_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .value_i     (in_i.value),
      .valid_i     (valid_c),
      .left_val_i  (left_val),
      .left_ins_i  (left_ins),
      .right_mid_i (right_mid),
      .val_o       (cell_val[i]),
      .ins_o       (cell_ins[i]),
      .mid_o       (cell_mid[i])
    );
  end

  // Sequencing of insert, emit and flush
  always_comb begin
    ctrl        = '0;
    count_d     = count_q;
    drain_d     = drain_q;
    out_value_d = out_value_q;
    out_final_d = out_final_q;
    out_valid_d = out_valid_q && !out_o.ready;

    if (accept_in) begin
      ctrl.insert = 1'b1;
      if (in_i.stream_end) begin
        count_d = count_plus;
        drain_d = 1'b1;
      end else if (count_plus > lim_eff) begin
        ctrl.pop    = 1'b1;
        out_value_d = cell_mid[0];
        out_final_d = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        count_d = count_plus;
      end
    end else if (drain_q && slot_free) begin
      ctrl.pop    = 1'b1;
      out_value_d = cell_mid[0];
      out_final_d = (count_q == CntW'(1));
      out_valid_d = 1'b1;
      count_d     = count_q - CntW'(1);
      if (count_q == CntW'(1)) begin
        drain_d = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_final_q <= out_final_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.final_result = out_final_q;

endmodule
